@@ hw/rtl/uart_sfr_pkg.sv @@
// shared constants and result type for the uart settings frame receiver
package uart_sfr_pkg;

    localparam logic [7:0] START_BYTE     = 8'h01;
    localparam logic [7:0] LENGTH_BYTE    = 8'd20;
    localparam logic [7:0] ZERO_START_BIT = 8'h40;

    // fixed byte positions inside the frame store
    localparam int IDX_START    = 0;
    localparam int IDX_LENGTH   = 1;
    localparam int IDX_DISPLAY  = 5;
    localparam int IDX_MAGNETS  = 6;
    localparam int IDX_WHEEL_HI = 7;
    localparam int IDX_WHEEL_LO = 8;
    localparam int IDX_THR_HI   = 16;
    localparam int IDX_THR_LO   = 17;
    localparam int IDX_CHECK    = 19;

    // one result beat, lowest field in the lowest bits
    typedef struct packed {
        logic        updated;
        logic [7:0]  frame_count;
        logic        settings_loaded;
        logic        zero_start;
        logic [7:0]  check_byte;
        logic [15:0] throttle_pwm;
        logic [15:0] wheel_size;
        logic [7:0]  magnet_count;
        logic [7:0]  display_mode;
    } result_t;

    localparam int RES_W   = $bits(result_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

@@ hw/rtl/uart_sfr_core.sv @@
// frame assembly, header check and settings latch, one byte per cycle while in_valid is high
module uart_sfr_core
    import uart_sfr_pkg::*;
#(
    parameter int FRAME_BYTES = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] rx_byte,
    output result_t    res
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

    logic [7:0]       store_reg [FRAME_BYTES];
    logic [7:0]       store_next [FRAME_BYTES];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             start_mark_reg, start_mark_next;
    logic             length_mark_reg, length_mark_next;
    result_t          set_reg;
    logic             header_ok;

    always_comb
    begin
        store_next       = store_reg;
        pos_next         = pos_reg;
        start_mark_next  = start_mark_reg;
        length_mark_next = length_mark_reg;
        header_ok        = 1'b0;
        res              = set_reg;
        res.updated      = 1'b0;
        if (in_valid)
        begin
            // start byte opens the frame only while none is open
            if (!start_mark_reg && rx_byte == START_BYTE)
            begin
                pos_next               = '0;
                start_mark_next        = 1'b1;
                store_next[IDX_START]  = START_BYTE;
            end
            // length byte goes in at the current position
            if (start_mark_next && !length_mark_reg && rx_byte == LENGTH_BYTE)
            begin
                length_mark_next     = 1'b1;
                store_next[pos_next] = rx_byte;
            end
            header_ok = (store_next[IDX_START] == START_BYTE) &&
                        (store_next[IDX_LENGTH] == LENGTH_BYTE);
            // bad header: drop the whole frame
            if (!header_ok && pos_next == POS_ONE)
            begin
                start_mark_next  = 1'b0;
                length_mark_next = 1'b0;
                pos_next         = '0;
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    store_next[i] = '0;
                end
            end
            if (header_ok && pos_next > POS_ONE)
            begin
                store_next[pos_next] = rx_byte;
            end
            // advance, wrap keeps the store
            if (pos_next == POS_LAST)
            begin
                pos_next         = '0;
                start_mark_next  = 1'b0;
                length_mark_next = 1'b0;
                res.frame_count  = set_reg.frame_count + 8'd1;
            end
            else
            begin
                pos_next = pos_next + POS_W'(1);
            end
            if (store_next[IDX_START] == START_BYTE && store_next[IDX_CHECK] != 8'd0)
            begin
                res.display_mode    = store_next[IDX_DISPLAY];
                res.magnet_count    = store_next[IDX_MAGNETS];
                res.wheel_size      = {store_next[IDX_WHEEL_HI], store_next[IDX_WHEEL_LO]};
                res.throttle_pwm    = {store_next[IDX_THR_HI], store_next[IDX_THR_LO]};
                res.check_byte      = store_next[IDX_CHECK];
                res.zero_start      = (store_next[IDX_DISPLAY] & ZERO_START_BIT) != 8'd0;
                res.settings_loaded = 1'b1;
                res.updated         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
            pos_reg         <= '0;
            start_mark_reg  <= 1'b0;
            length_mark_reg <= 1'b0;
            set_reg         <= '0;
        end
        else if (in_valid)
        begin
            store_reg       <= store_next;
            pos_reg         <= pos_next;
            start_mark_reg  <= start_mark_next;
            length_mark_reg <= length_mark_next;
            set_reg         <= res;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("write position out of range");

    a_marks: assert property (@(posedge clk) disable iff (!rst_n)
        length_mark_reg |-> start_mark_reg)
        else $error("length mark without start mark");

    a_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && res.updated) |=> set_reg.settings_loaded)
        else $error("settings load did not set loaded flag");

endmodule

@@ hw/rtl/uart_settings_frame_receiver_unit.sv @@
// top level: uart settings frame receiver with registered, skid-buffered output
//
// channel | dir | beat content
// s_*     | in  | tdata[7:0] rx_byte
// m_*     | out | tdata: display_mode, magnet_count, wheel_size, throttle_pwm,
//         |     |   check_byte, zero_start, settings_loaded, frame_count, updated
//
// one byte per cycle while s_tready is high, one result beat per byte, each result beat is registered
// the frame store, marks and settings update in the same cycle a byte is taken
// output register plus one skid entry: input keeps flowing while a result waits
// s_tready drops only when both output entries are full
// rst_n clears the frame store, position, marks, counter and settings at once
module uart_settings_frame_receiver_unit
    import uart_sfr_pkg::*;
#(
    parameter int FRAME_BYTES = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] display_mode, [15:8] magnet_count, [31:16] wheel_size,
    // [47:32] throttle_pwm, [55:48] check_byte, [56] zero_start,
    // [57] settings_loaded, [65:58] frame_count, [66] updated, rest zero
    output logic [TDATA_W-1:0] m_tdata
);

    result_t res;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    push, pop;

    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    // frame assembly and settings latch
    uart_sfr_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push),
        .rx_byte  (s_tdata),
        .res      (res)
    );

    // output stage: skid entry drains first
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_next = skid_data_reg;
            end
            else
            begin
                out_data_next = res;
            end
            out_valid_next  = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - RES_W)'(0), out_data_reg};

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("stalled beat not caught by skid entry");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> out_valid_reg)
        else $error("skid entry lost on drain");

endmodule

@@ dv/uart_settings_frame_receiver_unit_test.sv @@
// self-checking testbench for the uart settings frame receiver unit
module uart_settings_frame_receiver_unit_test;
    import uart_sfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN    = 20;
    localparam int DIR_ROWS     = 25;
    localparam int RAND_BYTES   = 1825;   // random bytes after the directed table
    localparam int LONG_HOLD    = 80;     // receiver hold-off, long enough to fill the output
    localparam int STALL_LIMIT  = 2000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 8;      // extra cycles after the last result

    localparam result_t RES_NONE = '0;
    // first complete frame: display 0x40, magnets 7, wheel 0x1234, throttle 0xabcd, check 0xff
    localparam result_t FIRST_LOAD = '{
        updated: 1'b1, frame_count: 8'd1, settings_loaded: 1'b1, zero_start: 1'b1,
        check_byte: 8'hFF, throttle_pwm: 16'hABCD, wheel_size: 16'h1234,
        magnet_count: 8'h07, display_mode: 8'h40
    };

    // one byte to send, with an optional pinned expectation
    typedef struct packed {
        logic [7:0] rx;
        logic       pinned;
        result_t    res;
    } stim_row_t;

    localparam stim_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b1, RES_NONE},      // line noise at position 0
        '{8'hFF, 1'b1, RES_NONE},      // bad header at position 1 clears the store and marks
        '{8'h01, 1'b1, RES_NONE},      // start byte
        '{8'h05, 1'b1, RES_NONE},      // wrong length byte, header dropped again
        '{8'h01, 1'b0, RES_NONE},      // start byte
        '{8'h14, 1'b0, RES_NONE},      // length byte
        '{8'hFF, 1'b0, RES_NONE},      // payload from position 2
        '{8'h00, 1'b0, RES_NONE},
        '{8'h14, 1'b0, RES_NONE},      // length value inside the payload
        '{8'h40, 1'b0, RES_NONE},      // display mode, zero-start bit only
        '{8'h07, 1'b0, RES_NONE},      // magnet count
        '{8'h12, 1'b0, RES_NONE},      // wheel size high
        '{8'h34, 1'b0, RES_NONE},      // wheel size low
        '{8'h01, 1'b0, RES_NONE},      // start value while a frame is open
        '{8'h80, 1'b0, RES_NONE},
        '{8'h55, 1'b0, RES_NONE},
        '{8'hAA, 1'b0, RES_NONE},
        '{8'h0F, 1'b0, RES_NONE},
        '{8'hF0, 1'b0, RES_NONE},
        '{8'h7F, 1'b0, RES_NONE},
        '{8'hAB, 1'b0, RES_NONE},      // throttle high
        '{8'hCD, 1'b0, RES_NONE},      // throttle low
        '{8'hFE, 1'b0, RES_NONE},
        '{8'hFF, 1'b1, FIRST_LOAD},    // check byte, position wraps and settings load
        '{8'h01, 1'b0, RES_NONE}       // start byte right after the wrap
    };

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // [7:0] rx_byte
    logic               m_tvalid;
    logic               m_tready;
    // [7:0] display_mode, [15:8] magnet_count, [31:16] wheel_size,
    // [47:32] throttle_pwm, [55:48] check_byte, [56] zero_start,
    // [57] settings_loaded, [65:58] frame_count, [66] updated, rest zero
    logic [TDATA_W-1:0] m_tdata;

    uart_settings_frame_receiver_unit #(
        .FRAME_BYTES (FRAME_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // frame assembly mirror, stepped once per accepted input beat
    logic [7:0] fr_store [FRAME_LEN];
    logic [4:0] fr_pos;
    bit         got_start;
    bit         got_len;
    logic [7:0] wraps;
    result_t    held_settings;   // latched fields plus the sticky loaded flag

    result_t    settings_due_q [$];   // expected result beats, oldest first
    stim_row_t  sent_rows_q [$];      // offered bytes waiting to be taken
    int         mismatches;
    int         bytes_offered;
    int         idle_cycles;
    bit         idle_on;
    bit         hold_once;

    // settings update for one received byte
    function automatic result_t advance_frame_rx(input logic [7:0] b);
        bit      hdr_ok;
        bit      upd;
        result_t r;
        upd = 1'b0;
        // start byte only counts while no frame is open
        if (!got_start && b == START_BYTE) begin
            fr_pos    = '0;
            got_start = 1'b1;
            fr_store[IDX_START] = b;
        end
        if (got_start && !got_len && b == LENGTH_BYTE) begin
            got_len = 1'b1;
            fr_store[fr_pos] = b;
        end
        hdr_ok = fr_store[IDX_START] == START_BYTE && fr_store[IDX_LENGTH] == LENGTH_BYTE;
        // header check happens at position 1 only
        if (!hdr_ok && fr_pos == 5'd1) begin
            got_start = 1'b0;
            got_len   = 1'b0;
            fr_pos    = '0;
            foreach (fr_store[i])
                fr_store[i] = '0;
        end
        if (hdr_ok && fr_pos > 5'd1)
            fr_store[fr_pos] = b;
        // wrap keeps the store but closes the frame
        if (fr_pos == 5'(FRAME_LEN - 1)) begin
            fr_pos    = '0;
            got_start = 1'b0;
            got_len   = 1'b0;
            wraps     = wraps + 8'd1;
        end
        else begin
            fr_pos = fr_pos + 5'd1;
        end
        // reload whenever the store holds a start byte and a nonzero check byte
        if (fr_store[IDX_START] == START_BYTE && fr_store[IDX_CHECK] != 8'h00) begin
            held_settings.display_mode    = fr_store[IDX_DISPLAY];
            held_settings.magnet_count    = fr_store[IDX_MAGNETS];
            held_settings.wheel_size      = {fr_store[IDX_WHEEL_HI], fr_store[IDX_WHEEL_LO]};
            held_settings.throttle_pwm    = {fr_store[IDX_THR_HI], fr_store[IDX_THR_LO]};
            held_settings.check_byte      = fr_store[IDX_CHECK];
            held_settings.zero_start      = (fr_store[IDX_DISPLAY] & ZERO_START_BIT) != 8'h00;
            held_settings.settings_loaded = 1'b1;
            upd = 1'b1;
        end
        r             = held_settings;
        r.frame_count = wraps;
        r.updated     = upd;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // random byte with weight on the values the block reacts to
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0, 1:    return 8'h00;
            2, 3:    return 8'hFF;
            4:       return START_BYTE;
            5:       return LENGTH_BYTE;
            6:       return ZERO_START_BIT;
            default: return 8'($urandom);
        endcase
    endfunction

    // offer one byte, possibly after a short gap, and wait until it is taken
    task automatic offer_byte(input stim_row_t row);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sent_rows_q.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.rx;
        bytes_offered++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor state starts in the reset state
    initial
    begin
        foreach (fr_store[i])
            fr_store[i] = '0;
        fr_pos        = '0;
        got_start     = 1'b0;
        got_len       = 1'b0;
        wraps         = '0;
        held_settings = RES_NONE;
        mismatches    = 0;
        bytes_offered = 0;
        idle_on       = 1'b1;
        hold_once     = 1'b0;
    end

    // result checker and predictor feed, both sampled at the rising edge
    always @(posedge clk)
    begin
        result_t   got;
        result_t   want;
        stim_row_t row;
        result_t   pred;
        if (rst_n) begin
            // retire the output beat before queueing the input beat of the same edge
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RES_W-1:0]);
                if (settings_due_q.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, got %0h",
                             $time, m_tdata);
                    mismatches++;
                end
                else begin
                    want = settings_due_q.pop_front();
                    check_field("display_mode", 16'(want.display_mode),
                                16'(got.display_mode));
                    check_field("magnet_count", 16'(want.magnet_count),
                                16'(got.magnet_count));
                    check_field("wheel_size", want.wheel_size, got.wheel_size);
                    check_field("throttle_pwm", want.throttle_pwm, got.throttle_pwm);
                    check_field("check_byte", 16'(want.check_byte), 16'(got.check_byte));
                    check_field("zero_start", 16'(want.zero_start), 16'(got.zero_start));
                    check_field("settings_loaded", 16'(want.settings_loaded),
                                16'(got.settings_loaded));
                    check_field("frame_count", 16'(want.frame_count),
                                16'(got.frame_count));
                    check_field("updated", 16'(want.updated), 16'(got.updated));
                    check_field("tdata padding", '0, 16'(m_tdata[TDATA_W-1:RES_W]));
                end
            end
            if (s_tvalid && s_tready) begin
                row  = sent_rows_q.pop_front();
                pred = advance_frame_rx(s_tdata);
                // pinned rows carry their own expectation, the predictor still advances
                settings_due_q.push_back(row.pinned ? row.res : pred);
            end
        end
    end

    // watchdog: ends the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, settings_due_q.size());
            $display("FAIL uart_settings_frame_receiver_unit");
            $finish;
        end
    end

    // receiver: random back-pressure bursts plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_once) begin
                hold_once = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // reset, directed table, random frames, drain and verdict
    initial
    begin
        int  next_mode_at;
        int  noise_len;
        bit  hold_done;
        bit  pause_done;
        stim_row_t row;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        next_mode_at = DIR_ROWS;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            offer_byte(DIRECTED[i]);

        // mostly well-formed frames with random payload, the rest noise bursts
        while (bytes_offered < DIR_ROWS + RAND_BYTES) begin
            if (bytes_offered >= next_mode_at) begin
                next_mode_at += 150;
                idle_on = $urandom_range(0, 3) != 0;
            end
            // last stretch runs with no gaps on either side
            if (bytes_offered >= DIR_ROWS + RAND_BYTES - 150)
                idle_on = 1'b0;
            if (!hold_done && bytes_offered >= 300) begin
                // receiver stalls while bytes keep coming, output and input fill up
                hold_done = 1'b1;
                hold_once = 1'b1;
            end
            if (!pause_done && bytes_offered >= 700) begin
                // sender goes quiet until every result is back
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                wait (settings_due_q.size() == 0);
            end
            row.pinned = 1'b0;
            row.res    = RES_NONE;
            if ($urandom_range(0, 9) < 7) begin
                row.rx = START_BYTE;
                offer_byte(row);
                row.rx = LENGTH_BYTE;
                offer_byte(row);
                repeat (FRAME_LEN - 2) begin
                    row.rx = pick_byte();
                    offer_byte(row);
                end
            end
            else begin
                noise_len = $urandom_range(1, 30);
                repeat (noise_len) begin
                    row.rx = pick_byte();
                    offer_byte(row);
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (settings_due_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS uart_settings_frame_receiver_unit");
        else
            $display("FAIL uart_settings_frame_receiver_unit");
        $finish;
    end

endmodule
